[sv/ole_pkg.sv]
// Shared types and constants for the ordered list engine.
// Used by ole_cell, ole_prio and ordered_list_engine; depends on nothing.
package ole_pkg;

  // List storage size and derived widths
  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int OUT_W    = 8;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Priority encoder grouping for search
  localparam int GRP        = 8;
  localparam int GRP_W      = 3;
  localparam int NUM_GROUPS = (CAPACITY + GRP - 1) / GRP;
  localparam int GSEL_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // What a cell does with its entry this cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     srch;
    logic     live;
  } cell_ctrl_t;

  typedef struct packed {
    mode_e              mode;
    logic [POS_W-1:0]   position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [OUT_W-1:0]   found_position;
    logic [OUT_W-1:0]   list_length;
  } out_item_t;

endpackage

[sv/ole_cell.sv]
// One storage cell of the list: holds one entry, shifts with its neighbours
// and compares against the search key. Depends on ole_pkg.
module ole_cell (
  input  logic                         clk_i,
  input  ole_pkg::cell_ctrl_t          ctrl_i,
  input  logic [ole_pkg::VAL_W-1:0]    left_i,
  input  logic [ole_pkg::VAL_W-1:0]    right_i,
  input  logic [ole_pkg::VAL_W-1:0]    value_i,
  output logic [ole_pkg::VAL_W-1:0]    entry_o,
  output logic                         match_o
);

  logic [ole_pkg::VAL_W-1:0] entry_d, entry_q;
  logic                      match_d, match_q;

  // Pick the next entry: hold, load, or take from a neighbour
  always_comb begin
    case (ctrl_i.op)
      ole_pkg::CELL_LOAD:  entry_d = value_i;
      ole_pkg::CELL_LEFT:  entry_d = left_i;
      ole_pkg::CELL_RIGHT: entry_d = right_i;
      default:             entry_d = entry_q;
    endcase
  end

  // Capture the compare result only on a search
  assign match_d = ctrl_i.srch ? (ctrl_i.live && (entry_q == value_i)) : match_q;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

[sv/ole_prio.sv]
// Two-stage first-match encoder over the cell match bits.
// Stage one is registered per group of cells; depends on ole_pkg.
module ole_prio (
  input  logic                            clk_i,
  input  logic [ole_pkg::CAPACITY-1:0]    match_i,
  output logic                            hit_o,
  output logic [ole_pkg::IDX_W-1:0]       idx_o
);

  localparam int PAD_W = ole_pkg::NUM_GROUPS * ole_pkg::GRP;

  logic [PAD_W-1:0]                 padded;
  logic [ole_pkg::NUM_GROUPS-1:0]   any_d, any_q;
  logic [ole_pkg::GRP_W-1:0]        sub_d [ole_pkg::NUM_GROUPS];
  logic [ole_pkg::GRP_W-1:0]        sub_q [ole_pkg::NUM_GROUPS];

  assign padded = PAD_W'(match_i);

  // Lowest set bit within each group
  always_comb begin
    for (int g = 0; g < ole_pkg::NUM_GROUPS; g++) begin
      any_d[g] = 1'b0;
      sub_d[g] = '0;
      for (int b = ole_pkg::GRP - 1; b >= 0; b--) begin
        if (padded[g*ole_pkg::GRP + b]) begin
          any_d[g] = 1'b1;
          sub_d[g] = ole_pkg::GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    any_q <= any_d;
    for (int g = 0; g < ole_pkg::NUM_GROUPS; g++) begin
      sub_q[g] <= sub_d[g];
    end
  end

  // Lowest group with a hit, joined with its in-group offset
  always_comb begin
    logic [ole_pkg::GSEL_W-1:0] gsel;
    logic [ole_pkg::GRP_W-1:0]  sub;
    gsel  = '0;
    sub   = '0;
    hit_o = 1'b0;
    for (int g = ole_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
      if (any_q[g]) begin
        hit_o = 1'b1;
        gsel  = ole_pkg::GSEL_W'(g);
        sub   = sub_q[g];
      end
    end
    idx_o = ole_pkg::IDX_W'({gsel, sub});
  end

endmodule

[sv/ordered_list_engine.sv]
// Top level of the ordered list engine: control, count and the cell chain.
// Depends on ole_pkg, ole_cell and ole_prio.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//  out     | output    | out_valid_o / out_ready_i | out_data_o (out_item_t)
//
// Append, insert and delete complete at the accepting edge, which also loads
// their result into the output register. A search passes through the
// parallel compare in the cells, the registered first encoder stage, then
// the second encoder stage into the output register.
// A new item is taken once the engine is idle and the output register is
// empty or being drained. Reset clears the count and control; no sweep of
// the cells is needed, since only entries below the count are ever read.
module ordered_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ole_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ole_pkg::out_item_t out_data_o
);

  localparam int CMP_W = ole_pkg::CMP_W;
  localparam int CNT_W = ole_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_GROUP = 3'b010,
    S_FINAL = 3'b100
  } state_e;

  state_e                    state_d, state_q;
  logic [CNT_W-1:0]          count_d, count_q;
  logic                      out_valid_d, out_valid_q;
  ole_pkg::out_item_t        out_d, out_q;

  logic                      in_fire;
  logic [CMP_W-1:0]          pos_ext, cnt_ext, idx_ext;
  logic                      full, ins_bad, del_bad;
  logic                      do_append, do_insert, do_delete, do_search;
  ole_pkg::status_e          status;

  logic [ole_pkg::VAL_W-1:0]    entry [ole_pkg::CAPACITY];
  logic [ole_pkg::CAPACITY-1:0] match;
  logic                         hit;
  logic [ole_pkg::IDX_W-1:0]    hit_idx;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // Range and fullness checks
  assign pos_ext = CMP_W'(in_data_i.position);
  assign cnt_ext = CMP_W'(count_q);
  assign idx_ext = pos_ext - CMP_W'(1);
  assign full    = (count_q == CNT_W'(ole_pkg::CAPACITY));
  assign ins_bad = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
  assign del_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

  // Decode the operation and its status
  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_delete = 1'b0;
    do_search = 1'b0;
    status    = ole_pkg::ST_OK;
    case (in_data_i.mode)
      ole_pkg::MODE_APPEND: begin
        if (full) status = ole_pkg::ST_FULL;
        else      do_append = in_fire;
      end
      ole_pkg::MODE_INSERT: begin
        if (ins_bad)   status = ole_pkg::ST_BADPOS;
        else if (full) status = ole_pkg::ST_FULL;
        else           do_insert = in_fire;
      end
      ole_pkg::MODE_DELETE: begin
        if (del_bad) status = ole_pkg::ST_BADPOS;
        else         do_delete = in_fire;
      end
      ole_pkg::MODE_SEARCH: do_search = in_fire;
      default: status = ole_pkg::ST_OK;
    endcase
  end

  // Cell chain with per-cell shift control
  for (genvar i = 0; i < ole_pkg::CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(i);
    ole_pkg::cell_ctrl_t        ctrl;
    logic [ole_pkg::VAL_W-1:0]  left, right;

    always_comb begin
      ctrl.op   = ole_pkg::CELL_HOLD;
      ctrl.srch = do_search;
      ctrl.live = (CELL_IDX < cnt_ext);
      if (do_append && (CELL_IDX == cnt_ext)) begin
        ctrl.op = ole_pkg::CELL_LOAD;
      end else if (do_insert && (CELL_IDX == idx_ext)) begin
        ctrl.op = ole_pkg::CELL_LOAD;
      end else if (do_insert && (CELL_IDX > idx_ext)) begin
        ctrl.op = ole_pkg::CELL_LEFT;
      end else if (do_delete && (CELL_IDX >= idx_ext)) begin
        ctrl.op = ole_pkg::CELL_RIGHT;
      end
    end

    if (i == 0) begin : g_first
      assign left = in_data_i.value;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    if (i == ole_pkg::CAPACITY - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_mid_r
      assign right = entry[i+1];
    end

    ole_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .value_i (in_data_i.value),
      .entry_o (entry[i]),
      .match_o (match[i])
    );
  end

  ole_prio u_prio (
    .clk_i   (clk_i),
    .match_i (match),
    .hit_o   (hit),
    .idx_o   (hit_idx)
  );

  // Advance count, state and output register
  always_comb begin
    logic [CNT_W-1:0] found;
    count_d     = count_q;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    found       = hit ? (CNT_W'(hit_idx) + CNT_W'(1)) : '0;

    if (do_append || do_insert) count_d = count_q + CNT_W'(1);
    else if (do_delete)         count_d = count_q - CNT_W'(1);

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == ole_pkg::MODE_SEARCH) begin
            state_d = S_GROUP;
          end else begin
            out_valid_d          = 1'b1;
            out_d.status         = status;
            out_d.found_position = '0;
            out_d.list_length    = ole_pkg::OUT_W'(count_d);
          end
        end
      end
      S_GROUP: state_d = S_FINAL;
      S_FINAL: begin
        state_d              = S_IDLE;
        out_valid_d          = 1'b1;
        out_d.status         = ole_pkg::ST_OK;
        out_d.found_position = ole_pkg::OUT_W'(found);
        out_d.list_length    = ole_pkg::OUT_W'(count_q);
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[bench/ordered_list_engine_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_engine: directed edge cases, a fill to
// capacity and back, then a long random mix. Depends on ole_pkg and the RTL.
module ordered_list_engine_test;

  localparam int CLK_LIMIT    = 400000;
  localparam int IDLE_PCT     = 17;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1260;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  ole_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  ole_pkg::out_item_t out_data_o;

  // Shadow copy of the list, updated as each item is accepted
  logic signed [ole_pkg::VAL_W-1:0] held_values [ole_pkg::CAPACITY];
  int                               held_count;
  int                               peak_length;

  ole_pkg::out_item_t pending_results [$];
  ole_pkg::out_item_t head_result;
  int                 items_sent;
  int                 results_checked;
  int                 error_count;
  int                 full_rejects;
  int                 badpos_rejects;
  int                 search_hits;
  bit                 quiet;
  int unsigned        cycle_count = 0;

  ordered_list_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock and cycle count
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Apply one operation to the shadow list and return the result it should give
  function automatic ole_pkg::out_item_t apply_list_op(input ole_pkg::in_item_t it);
    ole_pkg::out_item_t r;
    int                 p;
    int                 i;
    r.status         = ole_pkg::ST_OK;
    r.found_position = '0;
    p = int'(it.position);
    case (it.mode)
      ole_pkg::MODE_APPEND: begin
        if (held_count >= ole_pkg::CAPACITY) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          held_values[held_count] = it.value;
          held_count++;
        end
      end
      ole_pkg::MODE_INSERT: begin
        if (p < 1 || p > held_count + 1) begin
          r.status = ole_pkg::ST_BADPOS;
        end else if (held_count >= ole_pkg::CAPACITY) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          for (i = held_count; i > p - 1; i--) held_values[i] = held_values[i-1];
          held_values[p-1] = it.value;
          held_count++;
        end
      end
      ole_pkg::MODE_DELETE: begin
        if (p < 1 || p > held_count) begin
          r.status = ole_pkg::ST_BADPOS;
        end else begin
          for (i = p - 1; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
        end
      end
      default: begin
        for (i = held_count - 1; i >= 0; i--) begin
          if (held_values[i] == it.value) r.found_position = ole_pkg::OUT_W'(i + 1);
        end
        if (r.found_position != 0) search_hits++;
      end
    endcase
    if (r.status == ole_pkg::ST_FULL) full_rejects++;
    if (r.status == ole_pkg::ST_BADPOS) badpos_rejects++;
    if (held_count > peak_length) peak_length = held_count;
    r.list_length = ole_pkg::OUT_W'(held_count);
    return r;
  endfunction

  function automatic ole_pkg::in_item_t make_item(input ole_pkg::mode_e m, input int pos,
                                                  input logic [ole_pkg::VAL_W-1:0] v);
    ole_pkg::in_item_t it;
    it.mode     = m;
    it.position = ole_pkg::POS_W'(pos);
    it.value    = v;
    return it;
  endfunction

  // Half the values come from a small pool so duplicates are common
  function automatic logic [ole_pkg::VAL_W-1:0] pick_value();
    if ($urandom_range(1) == 0)
      return ole_pkg::VAL_W'($urandom_range(15)) - ole_pkg::VAL_W'(8);
    return $urandom;
  endfunction

  // Search keys: mostly an entry that is held, otherwise any value
  function automatic logic [ole_pkg::VAL_W-1:0] pick_key();
    if (held_count > 0 && $urandom_range(99) < 60)
      return held_values[$urandom_range(held_count - 1)];
    return pick_value();
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
    error_count++;
  endtask

  // Present one item, hold it until accepted, then maybe idle for a while
  task automatic send_item(input ole_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(apply_list_op(it));
    items_sent++;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 50) @(posedge clk_i);
    end
  endtask

  // Stall the result side at random, except in quiet stretches
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, list_length", -1, out_data_o.list_length);
      end else begin
        head_result = pending_results.pop_front();
        if (out_data_o.status !== head_result.status)
          report_mismatch("status", head_result.status, out_data_o.status);
        if (out_data_o.found_position !== head_result.found_position)
          report_mismatch("found_position", head_result.found_position,
                          out_data_o.found_position);
        if (out_data_o.list_length !== head_result.list_length)
          report_mismatch("list_length", head_result.list_length, out_data_o.list_length);
        results_checked++;
      end
    end
  end

  // Empty-list rejects, extreme values, head/tail/middle edits, first-match search
  task automatic test_directed_edges();
    send_item(make_item(ole_pkg::MODE_DELETE, 1, '0));
    send_item(make_item(ole_pkg::MODE_DELETE, 0, '0));
    send_item(make_item(ole_pkg::MODE_INSERT, 0, 32'h1234_5678));
    send_item(make_item(ole_pkg::MODE_INSERT, 2, 32'h1234_5678));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, '0));
    send_item(make_item(ole_pkg::MODE_APPEND, 0, 32'h7FFF_FFFF));
    send_item(make_item(ole_pkg::MODE_APPEND, 0, 32'h8000_0000));
    send_item(make_item(ole_pkg::MODE_INSERT, 1, 32'h0000_0000));
    send_item(make_item(ole_pkg::MODE_INSERT, 4, 32'hFFFF_FFFF));
    send_item(make_item(ole_pkg::MODE_INSERT, 255, 32'h0F0F_0F0F));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, 32'h8000_0000));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, 32'hFFFF_FFFF));
    send_item(make_item(ole_pkg::MODE_APPEND, 0, 32'h0000_0000));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, 32'h0000_0000));
    send_item(make_item(ole_pkg::MODE_DELETE, 6, '0));
    send_item(make_item(ole_pkg::MODE_DELETE, 5, 32'hFFFF_FFFF));
    send_item(make_item(ole_pkg::MODE_DELETE, 1, '0));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, 32'h0000_0000));
    send_item(make_item(ole_pkg::MODE_DELETE, 2, '0));
    send_item(make_item(ole_pkg::MODE_SEARCH, 255, 32'h5555_5555));
    send_item(make_item(ole_pkg::MODE_APPEND, 170, 32'hAAAA_AAAA));
  endtask

  // Fill to capacity, poke every full-list case, then drain to empty
  task automatic test_fill_to_capacity();
    while (held_count < ole_pkg::CAPACITY) begin
      if ($urandom_range(1) == 0) begin
        send_item(make_item(ole_pkg::MODE_APPEND, $urandom_range(255), pick_value()));
      end else begin
        send_item(make_item(ole_pkg::MODE_INSERT, $urandom_range(1, held_count + 1),
                            pick_value()));
      end
    end
    send_item(make_item(ole_pkg::MODE_APPEND, 0, pick_value()));
    send_item(make_item(ole_pkg::MODE_INSERT, 1, pick_value()));
    send_item(make_item(ole_pkg::MODE_INSERT, ole_pkg::CAPACITY + 1, pick_value()));
    send_item(make_item(ole_pkg::MODE_INSERT, ole_pkg::CAPACITY + 2, pick_value()));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, held_values[ole_pkg::CAPACITY-1]));
    send_item(make_item(ole_pkg::MODE_SEARCH, 0, $urandom));
    send_item(make_item(ole_pkg::MODE_DELETE, ole_pkg::CAPACITY + 1, '0));
    send_item(make_item(ole_pkg::MODE_DELETE, ole_pkg::CAPACITY, '0));
    send_item(make_item(ole_pkg::MODE_INSERT, ole_pkg::CAPACITY, pick_value()));
    while (held_count > 0) begin
      if ($urandom_range(9) == 0) send_item(make_item(ole_pkg::MODE_SEARCH, 0, pick_key()));
      send_item(make_item(ole_pkg::MODE_DELETE, $urandom_range(1, held_count), $urandom));
    end
    send_item(make_item(ole_pkg::MODE_DELETE, 1, '0));
  endtask

  // Random mix steered towards a wandering target length, with some noise
  task automatic test_random_mix(input int n_items);
    int                k;
    int                target;
    ole_pkg::in_item_t it;
    target = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 200 == 0) begin
        case ($urandom_range(3))
          0:       target = 0;
          1:       target = ole_pkg::CAPACITY;
          default: target = $urandom_range(ole_pkg::CAPACITY);
        endcase
      end
      // Hold both sides busy through one long stretch
      quiet = (k >= 400 && k < 650);
      if ($urandom_range(99) < 10) begin
        it = make_item(ole_pkg::mode_e'($urandom_range(3)), $urandom_range(255), $urandom);
      end else if ($urandom_range(9) < 3) begin
        it = make_item(ole_pkg::MODE_SEARCH, $urandom_range(255), pick_key());
      end else if (held_count < target || (held_count == target && $urandom_range(1))) begin
        if ($urandom_range(2) == 0) begin
          it = make_item(ole_pkg::MODE_APPEND, $urandom_range(255), pick_value());
        end else begin
          it = make_item(ole_pkg::MODE_INSERT, $urandom_range(1, held_count + 1),
                         pick_value());
        end
      end else begin
        it = make_item(ole_pkg::MODE_DELETE, $urandom_range(1, held_count), $urandom);
      end
      send_item(it);
    end
    quiet = 1'b0;
  endtask

  // Abandon a hung run
  initial begin
    wait (cycle_count >= CLK_LIMIT);
    $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    held_count  = 0;
    peak_length = 0;
    quiet       = 1'b0;
    items_sent = 0; results_checked = 0; error_count = 0;
    full_rejects = 0; badpos_rejects = 0; search_hits = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_fill_to_capacity();
    test_random_mix(RANDOM_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations (edge cases, fill to %0d entries and back, random mix)",
             items_sent, peak_length);
    $display("Checked %0d results; rejected as full %0d, as bad position %0d; hits %0d",
             results_checked, full_rejects, badpos_rejects, search_hits);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ole_pkg.sv
sv/ole_cell.sv
sv/ole_prio.sv
sv/ordered_list_engine.sv
bench/ordered_list_engine_test.sv
